// ----- rtl/positional_list_shift_engine_defines.svh -----
// ---------------------------------------------------------------------------
// positional list shift engine assertion macros
// concurrent checks, removed from synthesis builds
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_SHIFT_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_SHIFT_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define PLSE_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("plse check failed");
`define PLSE_NEVER(lbl, clk_s, rst_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(expr)) \
    else $error("plse forbidden condition");
`else
`define PLSE_ASSERT(lbl, clk_s, rst_s, prop)
`define PLSE_NEVER(lbl, clk_s, rst_s, expr)
`endif
`endif

// ----- rtl/plse_pkg.sv -----
// ---------------------------------------------------------------------------
// plse_pkg
// shared types and constants of the positional list shift engine
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package plse_pkg;

  localparam int LIST_DEPTH_DEF   = 16;
  localparam int ID_BITS_DEF      = 32;
  localparam int PAYLOAD_BITS_DEF = 24;
  localparam int CMP_W            = 8;

  typedef enum logic [3:0] {
    CMD_INSERT_AT   = 4'd0,
    CMD_APPEND      = 4'd1,
    CMD_DELETE_AT   = 4'd2,
    CMD_DELETE_LAST = 4'd3,
    CMD_FIND_ID     = 4'd4,
    CMD_READ_AT     = 4'd5,
    CMD_WRITE_AT    = 4'd6,
    CMD_PURGE       = 4'd7,
    CMD_CLEAR       = 4'd8
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_NOTHING   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RUN
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic step;
  } ctrl_t;

  typedef struct packed {
    logic out_free;
    logic run_start;
    logic run_last;
  } stat_t;

endpackage

// ----- rtl/plse_ctrl.sv -----
// ---------------------------------------------------------------------------
// plse_ctrl
// sequencer: takes an item, executes it, steps purge runs
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module plse_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  plse_pkg::stat_t stat,
  output plse_pkg::ctrl_t ctrl
);
  import plse_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.out_free) state_next = stat.run_start ? S_RUN : S_IDLE;
      end
      S_RUN: begin
        if (stat.out_free && stat.run_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl     = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall   = rst;
        ctrl.latch = in_valid && !rst;
      end
      S_EXEC:  ctrl.exec = stat.out_free;
      S_RUN:   ctrl.step = stat.out_free;
      default: in_stall = 1'b1;
    endcase
  end

endmodule

// ----- rtl/plse_datapath.sv -----
// ---------------------------------------------------------------------------
// plse_datapath
// entry cells with shift network, command decode and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "positional_list_shift_engine_defines.svh"
module plse_datapath #(
  parameter int LIST_DEPTH   = plse_pkg::LIST_DEPTH_DEF,
  parameter int ID_BITS      = plse_pkg::ID_BITS_DEF,
  parameter int PAYLOAD_BITS = plse_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  plse_pkg::ctrl_t         ctrl,
  output plse_pkg::stat_t         stat,
  input  logic [3:0]              cmd,
  input  logic [4:0]              position,
  input  logic [ID_BITS-1:0]      entry_id,
  input  logic [PAYLOAD_BITS-1:0] entry_payload,
  input  logic                    entry_flag,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              status,
  output logic [3:0]              found_position,
  output logic [ID_BITS-1:0]      out_id,
  output logic [PAYLOAD_BITS-1:0] out_payload,
  output logic                    out_flag,
  output logic [4:0]              entry_count,
  output logic                    last_of_run
);
  import plse_pkg::*;

  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam logic [CMP_W-1:0] DEPTH_X = CMP_W'(LIST_DEPTH);

  // latched item
  logic [3:0]              cmd_q;
  logic [4:0]              pos_q;
  logic [ID_BITS-1:0]      id_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic                    flag_q;

  // list cells
  logic [CNT_W-1:0]        count;
  logic [ID_BITS-1:0]      ids   [LIST_DEPTH];
  logic [PAYLOAD_BITS-1:0] pays  [LIST_DEPTH];
  logic                    flags [LIST_DEPTH];

  // purge run
  logic [LIST_DEPTH-1:0]   mask;
  logic [CNT_W-1:0]        removed;
  logic [CNT_W-1:0]        fcount;

  logic [CMP_W-1:0]        cnt_x, pos_x, tgt_x;
  logic [LIST_DEPTH-1:0]   hit, unfl;
  logic                    hit_any;
  logic [IDX_W-1:0]        hit_idx, orig_idx, cur_idx, rd_idx, sh_idx;
  logic                    sh_ins, sh_del, sh_wr, load;
  logic [CNT_W-1:0]        count_next;
  status_t                 res_status;
  logic [3:0]              res_pos;
  logic                    res_entry, res_last;
  logic [4:0]              res_count;

  assign cnt_x = CMP_W'(count);
  assign pos_x = CMP_W'(pos_q);
  assign tgt_x = (cmd_t'(cmd_q) == CMD_DELETE_LAST) ? cnt_x - CMP_W'(1) : pos_x;

  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      hit[i]  = (CMP_W'(i) < cnt_x) && (ids[i] == id_q);
      unfl[i] = (CMP_W'(i) < cnt_x) && !flags[i];
    end
  end

  always_comb begin
    hit_idx  = '0;
    orig_idx = '0;
    for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
      if (hit[i])  hit_idx  = IDX_W'(i);
      if (mask[i]) orig_idx = IDX_W'(i);
    end
  end

  assign hit_any = |hit;
  assign cur_idx = orig_idx - IDX_W'(removed);

  always_comb begin
    res_status     = ST_OK;
    res_pos        = '0;
    res_entry      = 1'b0;
    res_last       = 1'b1;
    sh_ins         = 1'b0;
    sh_del         = 1'b0;
    sh_wr          = 1'b0;
    sh_idx         = tgt_x[IDX_W-1:0];
    rd_idx         = tgt_x[IDX_W-1:0];
    count_next     = count;
    stat.run_start = 1'b0;
    if (ctrl.step) begin
      rd_idx     = cur_idx;
      sh_idx     = cur_idx;
      sh_del     = 1'b1;
      res_pos    = 4'(orig_idx);
      res_entry  = 1'b1;
      res_last   = ((mask & (mask - 1'b1)) == '0);
      count_next = count - 1'b1;
    end else begin
      unique case (cmd_q)
        CMD_INSERT_AT, CMD_APPEND: begin
          if (cnt_x == DEPTH_X) begin
            res_status = ST_FULL;
          end else if (cmd_t'(cmd_q) == CMD_APPEND) begin
            sh_ins     = 1'b1;
            sh_idx     = cnt_x[IDX_W-1:0];
            res_pos    = cnt_x[3:0];
            count_next = count + 1'b1;
          end else if (pos_x > cnt_x) begin
            res_status = ST_BAD_INDEX;
          end else begin
            sh_ins     = 1'b1;
            sh_idx     = pos_x[IDX_W-1:0];
            res_pos    = pos_x[3:0];
            count_next = count + 1'b1;
          end
        end
        CMD_DELETE_AT, CMD_DELETE_LAST, CMD_READ_AT, CMD_WRITE_AT: begin
          if (cnt_x == '0) begin
            res_status = ST_EMPTY;
          end else if (tgt_x >= cnt_x) begin
            res_status = ST_BAD_INDEX;
          end else begin
            res_pos = tgt_x[3:0];
            if (cmd_t'(cmd_q) == CMD_WRITE_AT) begin
              sh_wr = 1'b1;
            end else begin
              res_entry = 1'b1;
              if (cmd_t'(cmd_q) != CMD_READ_AT) begin
                sh_del     = 1'b1;
                count_next = count - 1'b1;
              end
            end
          end
        end
        CMD_FIND_ID: begin
          rd_idx = hit_idx;
          if (hit_any) begin
            res_pos   = 4'(hit_idx);
            res_entry = 1'b1;
          end else begin
            res_status = ST_NOT_FOUND;
          end
        end
        CMD_PURGE: begin
          if (cnt_x == '0) res_status = ST_EMPTY;
          else if (unfl == '0) res_status = ST_NOTHING;
          else stat.run_start = 1'b1;
        end
        CMD_CLEAR: count_next = '0;
        default: res_status = ST_OK;
      endcase
    end
  end

  assign res_count     = ctrl.step ? 5'(fcount) : 5'(count_next);
  assign stat.out_free = !out_valid || !out_stall;
  assign stat.run_last = res_last;
  assign load          = ctrl.step || (ctrl.exec && !stat.run_start);

  // shift network
  genvar j;
  generate
    for (j = 0; j < LIST_DEPTH; j++) begin : g_cell
      always_ff @(posedge clk) begin
        if ((ctrl.exec || ctrl.step) && (sh_ins || sh_wr) && IDX_W'(j) == sh_idx) begin
          ids[j]   <= id_q;
          pays[j]  <= pay_q;
          flags[j] <= flag_q;
        end else if ((ctrl.exec || ctrl.step) && sh_ins && IDX_W'(j) > sh_idx
                     && CMP_W'(j) <= cnt_x) begin
          if (j > 0) begin
            ids[j]   <= ids[(j > 0) ? j - 1 : 0];
            pays[j]  <= pays[(j > 0) ? j - 1 : 0];
            flags[j] <= flags[(j > 0) ? j - 1 : 0];
          end
        end else if ((ctrl.exec || ctrl.step) && sh_del && IDX_W'(j) >= sh_idx
                     && CMP_W'(j + 1) < cnt_x) begin
          if (j < LIST_DEPTH - 1) begin
            ids[j]   <= ids[(j < LIST_DEPTH - 1) ? j + 1 : j];
            pays[j]  <= pays[(j < LIST_DEPTH - 1) ? j + 1 : j];
            flags[j] <= flags[(j < LIST_DEPTH - 1) ? j + 1 : j];
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
      mask      <= '0;
    end else begin
      if (ctrl.exec || ctrl.step) count <= count_next;
      if (ctrl.exec && stat.run_start) begin
        mask <= unfl;
      end else if (ctrl.step) begin
        mask[orig_idx] <= 1'b0;
      end
      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      cmd_q  <= cmd;
      pos_q  <= position;
      id_q   <= entry_id;
      pay_q  <= entry_payload;
      flag_q <= entry_flag;
    end
    if (ctrl.exec && stat.run_start) begin
      removed <= '0;
      fcount  <= count - CNT_W'($countones(unfl));
    end else if (ctrl.step) begin
      removed <= removed + 1'b1;
    end
    if (load) begin
      status         <= res_status;
      found_position <= res_pos;
      out_id         <= res_entry ? ids[rd_idx] : '0;
      out_payload    <= res_entry ? pays[rd_idx] : '0;
      out_flag       <= res_entry ? flags[rd_idx] : 1'b0;
      entry_count    <= res_count;
      last_of_run    <= res_last;
    end
  end

  `PLSE_NEVER(a_count_range, clk, rst, CMP_W'(count) > DEPTH_X)
  `PLSE_ASSERT(a_step_has_work, clk, rst, ctrl.step |-> (mask != '0))
  `PLSE_ASSERT(a_load_shows, clk, rst, load |=> out_valid)
  `PLSE_ASSERT(a_run_ends_empty, clk, rst, (ctrl.step && res_last) |=> (mask == '0))

endmodule

// ----- rtl/positional_list_shift_engine.sv -----
// ---------------------------------------------------------------------------
// positional_list_shift_engine
// ordered list of entries with insert, delete, find, read, write and purge
// ---------------------------------------------------------------------------
// input channel: in_valid / in_stall carry one command item (cmd, position,
//   entry_id, entry_payload, entry_flag); taken when in_valid and not in_stall
// output channel: out_valid / out_stall carry result items
// each item is taken in the idle state and executed in the exec state once the result
//   register is free; the result register then frees the input
// purge that removes k entries gives k results, one a cycle unless the receiver stalls,
//   each removing one cell through the shift network; count reports the final value
// all cells shift or compare in parallel within an execute or purge step cycle
// reset empties the list at once; no clearing pass
// when the receiver stalls the result holds and the engine waits before
//   loading the next result; a new item may still be taken while idle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module positional_list_shift_engine #(
  parameter int LIST_DEPTH   = plse_pkg::LIST_DEPTH_DEF,
  parameter int ID_BITS      = plse_pkg::ID_BITS_DEF,
  parameter int PAYLOAD_BITS = plse_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [3:0]              cmd,
  input  logic [4:0]              position,
  input  logic [ID_BITS-1:0]      entry_id,
  input  logic [PAYLOAD_BITS-1:0] entry_payload,
  input  logic                    entry_flag,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              status,
  output logic [3:0]              found_position,
  output logic [ID_BITS-1:0]      out_id,
  output logic [PAYLOAD_BITS-1:0] out_payload,
  output logic                    out_flag,
  output logic [4:0]              entry_count,
  output logic                    last_of_run
);
  import plse_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  plse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  plse_datapath #(
    .LIST_DEPTH   (LIST_DEPTH),
    .ID_BITS      (ID_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .stat           (stat),
    .cmd            (cmd),
    .position       (position),
    .entry_id       (entry_id),
    .entry_payload  (entry_payload),
    .entry_flag     (entry_flag),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .found_position (found_position),
    .out_id         (out_id),
    .out_payload    (out_payload),
    .out_flag       (out_flag),
    .entry_count    (entry_count),
    .last_of_run    (last_of_run)
  );

endmodule

// ----- tb/sv/positional_list_shift_engine_tb.sv -----
// ---------------------------------------------------------------------------
// positional_list_shift_engine_tb
// drives list commands through the valid/stall input channel, predicts the
// results with an internal list model and compares every result item field
// by field; idling on both sides is varied across three phases
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module positional_list_shift_engine_tb;
  import plse_pkg::*;

  localparam int DEPTH = 16;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  found_position;
    logic [31:0] out_id;
    logic [23:0] out_payload;
    logic        out_flag;
    logic [4:0]  entry_count;
    logic        last_of_run;
  } list_result_t;

  class list_scoreboard;
    logic [31:0] ids[DEPTH];
    logic [23:0] pays[DEPTH];
    logic        flags[DEPTH];
    int          count;
    list_result_t pending[$];
    int          errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    function void push(logic [2:0] st, int pos, logic [31:0] id, logic [23:0] pay,
                       logic fl, logic last);
      list_result_t r;
      r.status = st;
      r.found_position = pos[3:0];
      r.out_id = id;
      r.out_payload = pay;
      r.out_flag = fl;
      r.entry_count = count[4:0];
      r.last_of_run = last;
      pending.push_back(r);
    endfunction

    function void drop_at(int idx);
      for (int i = idx; i < count - 1; i++) begin
        ids[i] = ids[i+1];
        pays[i] = pays[i+1];
        flags[i] = flags[i+1];
      end
      count--;
    endfunction

    function void note_command(logic [3:0] c, logic [4:0] p, logic [31:0] id,
                               logic [23:0] pay, logic fl);
      int pos;
      int i;
      int orig;
      list_result_t gone[$];
      list_result_t g;
      pos = p;
      case (c)
        CMD_INSERT_AT: begin
          if (count >= DEPTH) push(ST_FULL, 0, 0, 0, 0, 1);
          else if (pos > count) push(ST_BAD_INDEX, 0, 0, 0, 0, 1);
          else begin
            for (i = count; i > pos; i--) begin
              ids[i] = ids[i-1];
              pays[i] = pays[i-1];
              flags[i] = flags[i-1];
            end
            ids[pos] = id;
            pays[pos] = pay;
            flags[pos] = fl;
            count++;
            push(ST_OK, pos, 0, 0, 0, 1);
          end
        end
        CMD_APPEND: begin
          if (count >= DEPTH) push(ST_FULL, 0, 0, 0, 0, 1);
          else begin
            ids[count] = id;
            pays[count] = pay;
            flags[count] = fl;
            count++;
            push(ST_OK, count - 1, 0, 0, 0, 1);
          end
        end
        CMD_DELETE_AT, CMD_DELETE_LAST, CMD_READ_AT, CMD_WRITE_AT: begin
          if (count == 0) push(ST_EMPTY, 0, 0, 0, 0, 1);
          else begin
            if (c == CMD_DELETE_LAST) pos = count - 1;
            if (pos >= count) push(ST_BAD_INDEX, 0, 0, 0, 0, 1);
            else if (c == CMD_WRITE_AT) begin
              ids[pos] = id;
              pays[pos] = pay;
              flags[pos] = fl;
              push(ST_OK, pos, 0, 0, 0, 1);
            end else begin
              g.out_id = ids[pos];
              g.out_payload = pays[pos];
              g.out_flag = flags[pos];
              if (c != CMD_READ_AT) drop_at(pos);
              push(ST_OK, pos, g.out_id, g.out_payload, g.out_flag, 1);
            end
          end
        end
        CMD_FIND_ID: begin
          for (i = 0; i < count; i++)
            if (ids[i] == id) break;
          if (i < count) push(ST_OK, i, ids[i], pays[i], flags[i], 1);
          else push(ST_NOT_FOUND, 0, 0, 0, 0, 1);
        end
        CMD_PURGE: begin
          if (count == 0) push(ST_EMPTY, 0, 0, 0, 0, 1);
          else begin
            i = 0;
            orig = 0;
            while (i < count) begin
              if (flags[i] == 1'b0) begin
                g.found_position = orig[3:0];
                g.out_id = ids[i];
                g.out_payload = pays[i];
                g.out_flag = 1'b0;
                gone.push_back(g);
                drop_at(i);
              end else i++;
              orig++;
            end
            if (gone.size() == 0) push(ST_NOTHING, 0, 0, 0, 0, 1);
            else
              foreach (gone[k])
                push(ST_OK, gone[k].found_position, gone[k].out_id,
                     gone[k].out_payload, 1'b0, k == gone.size() - 1);
          end
        end
        CMD_CLEAR: begin
          count = 0;
          push(ST_OK, 0, 0, 0, 0, 1);
        end
        default: push(ST_OK, 0, 0, 0, 0, 1);
      endcase
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result item, status %0d", got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.found_position !== want.found_position) begin
        $error("found_position: expected %0d, got %0d", want.found_position,
               got.found_position);
        errors++;
      end
      if (got.out_id !== want.out_id) begin
        $error("out_id: expected %h, got %h", want.out_id, got.out_id);
        errors++;
      end
      if (got.out_payload !== want.out_payload) begin
        $error("out_payload: expected %h, got %h", want.out_payload, got.out_payload);
        errors++;
      end
      if (got.out_flag !== want.out_flag) begin
        $error("out_flag: expected %0d, got %0d", want.out_flag, got.out_flag);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
        errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  cmd;
  logic [4:0]  position;
  logic [31:0] entry_id;
  logic [23:0] entry_payload;
  logic        entry_flag;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic [3:0]  found_position;
  logic [31:0] out_id;
  logic [23:0] out_payload;
  logic        out_flag;
  logic [4:0]  entry_count;
  logic        last_of_run;

  list_scoreboard board;
  int send_idle_pct;
  int recv_idle_pct;
  logic [31:0] id_pool[8];

  positional_list_shift_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .position(position), .entry_id(entry_id),
    .entry_payload(entry_payload), .entry_flag(entry_flag),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .found_position(found_position), .out_id(out_id),
    .out_payload(out_payload), .out_flag(out_flag),
    .entry_count(entry_count), .last_of_run(last_of_run)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // receiver side: random stall, result taken when valid and not stalled
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        board.check_result({status, found_position, out_id, out_payload, out_flag,
                            entry_count, last_of_run});
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_item(logic [3:0] c, logic [4:0] p, logic [31:0] id,
                           logic [23:0] pay, logic fl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    position <= p;
    entry_id <= id;
    entry_payload <= pay;
    entry_flag <= fl;
    do @(posedge clk); while (in_stall);
    board.note_command(c, p, id, pay, fl);
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  task automatic send_random();
    logic [3:0] c;
    logic [4:0] p;
    logic [31:0] id;
    int r;
    r = $urandom_range(99);
    if (r < 22) c = CMD_INSERT_AT;
    else if (r < 40) c = CMD_APPEND;
    else if (r < 52) c = CMD_DELETE_AT;
    else if (r < 58) c = CMD_DELETE_LAST;
    else if (r < 68) c = CMD_FIND_ID;
    else if (r < 78) c = CMD_READ_AT;
    else if (r < 87) c = CMD_WRITE_AT;
    else if (r < 94) c = CMD_PURGE;
    else if (r < 96) c = CMD_CLEAR;
    else c = 4'($urandom_range(15, 9));
    if ($urandom_range(9) < 8 && board.count > 0)
      p = 5'($urandom_range(board.count - (c == CMD_INSERT_AT ? 0 : 1)));
    else p = 5'($urandom_range(31));
    id = ($urandom_range(3) == 0) ? $urandom() : id_pool[$urandom_range(7)];
    send_item(c, p, id, 24'($urandom()), ($urandom_range(2) != 0));
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = '0;
    position = '0;
    entry_id = '0;
    entry_payload = '0;
    entry_flag = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (id_pool[k]) id_pool[k] = $urandom();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list cases, fill to full, extremes, purge forms
    send_item(CMD_DELETE_AT, 0, 0, 0, 0);
    send_item(CMD_DELETE_LAST, 0, 0, 0, 0);
    send_item(CMD_READ_AT, 0, 0, 0, 0);
    send_item(CMD_WRITE_AT, 0, 0, 0, 0);
    send_item(CMD_FIND_ID, 0, 0, 0, 0);
    send_item(CMD_PURGE, 0, 0, 0, 0);
    send_item(CMD_INSERT_AT, 5'd1, 32'hFFFF_FFFF, 24'hFF_FFFF, 1);
    for (int k = 0; k < 16; k++)
      send_item(k[0] ? CMD_APPEND : CMD_INSERT_AT, 5'(k), 32'(k), 24'(k * 3), k[1]);
    send_item(CMD_APPEND, 0, 0, 0, 0);
    send_item(CMD_INSERT_AT, 0, 0, 0, 0);
    send_item(CMD_READ_AT, 5'd31, 0, 0, 0);
    send_item(CMD_WRITE_AT, 5'd15, 32'hFFFF_FFFF, 24'hFF_FFFF, 1);
    send_item(CMD_FIND_ID, 0, 32'hFFFF_FFFF, 0, 0);
    send_item(CMD_PURGE, 0, 0, 0, 0);
    send_item(CMD_PURGE, 0, 0, 0, 0);
    send_item(4'd15, 5'd31, 32'hFFFF_FFFF, 24'hFF_FFFF, 1);
    send_item(CMD_CLEAR, 0, 0, 0, 0);
    go_quiet();

    send_idle_pct = 21;
    recv_idle_pct = 56;
    repeat (116) send_random();
    go_quiet();
    send_idle_pct = 56;
    recv_idle_pct = 21;
    repeat (116) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (116) send_random();
    go_quiet();
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
